// File: rtl/core/sks_pkg.sv
// Shared types, constants and codes for the sorted key set.
package sks_pkg;

  localparam int CAPACITY = 256;
  localparam int KEY_BITS = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Transaction field widths
  localparam int FUNC_W   = 2;
  localparam int KEYF_W   = 64;
  localparam int INDEX_W  = 8;
  localparam int STATUS_W = 3;
  localparam int POSF_W   = 9;

  localparam int IN_FUNC_LSB  = 0;
  localparam int IN_KEY_LSB   = IN_FUNC_LSB + FUNC_W;
  localparam int IN_INDEX_LSB = IN_KEY_LSB + KEYF_W;
  localparam int IN_BITS      = IN_INDEX_LSB + INDEX_W;
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;

  localparam int OUT_STATUS_LSB = 0;
  localparam int OUT_ENTRY_LSB  = OUT_STATUS_LSB + STATUS_W;
  localparam int OUT_BOUND_LSB  = OUT_ENTRY_LSB + KEYF_W;
  localparam int OUT_COUNT_LSB  = OUT_BOUND_LSB + POSF_W;
  localparam int OUT_BITS       = OUT_COUNT_LSB + POSF_W;
  localparam int OUT_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_SPARE = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_HIT       = 3'd3,
    ST_MISS      = 3'd4,
    ST_ENTRY     = 3'd5,
    ST_RANGE     = 3'd6,
    ST_UNUSED    = 3'd7
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_BUSY = 1'b1
  } state_t;

  // Per-cell flags seen by the next cell up the row
  typedef struct packed {
    logic valid;
    logic lt;     // valid and stored key below the search key
    logic ge;     // valid and stored key not below the search key
    logic eq;     // valid and stored key equal to the search key
  } cell_flags_t;

  // Sequencer strobes
  typedef struct packed {
    logic ready;   // may take an input transaction
    logic cmp_en;  // load compare flags in every cell
    logic commit;  // finish the operation and load the result register
  } ctl_t;

endpackage

// File: rtl/core/sks_cell.sv
// One storage cell of the sorted row: key, valid bit and compare flags.
module sks_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmp_en,
  input  sks_pkg::key_t       cmp_key,
  input  logic                ins_en,
  input  sks_pkg::key_t       new_key,
  input  sks_pkg::key_t       prev_key,
  input  sks_pkg::cell_flags_t prev_flags,
  output sks_pkg::key_t       key_o,
  output sks_pkg::cell_flags_t flags_o
);

  sks_pkg::key_t key_r;
  sks_pkg::key_t key_nxt;
  logic          valid_r;
  logic          valid_nxt;
  logic          lt_r;
  logic          eq_r;

  // On insertion cells above the bound take the neighbour's key, the bound cell takes the new one
  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    if (ins_en) begin
      if (prev_flags.ge) begin
        key_nxt   = prev_key;
        valid_nxt = 1'b1;
      end else if (prev_flags.lt && !lt_r) begin
        key_nxt   = new_key;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      lt_r    <= 1'b0;
      eq_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (cmp_en) begin
        lt_r <= valid_r && (key_r < cmp_key);
        eq_r <= valid_r && (key_r == cmp_key);
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_o         = key_r;
  assign flags_o.valid = valid_r;
  assign flags_o.lt    = lt_r;
  assign flags_o.ge    = valid_r && !lt_r;
  assign flags_o.eq    = eq_r;

endmodule

// File: rtl/core/sks_ctrl.sv
// Two-state sequencer: compare on accept, then resolve and commit.
module sks_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            out_free,
  output sks_pkg::ctl_t   ctl
);

  sks_pkg::state_t state_r;
  sks_pkg::state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sks_pkg::S_IDLE: begin
        if (in_valid) state_nxt = sks_pkg::S_BUSY;
      end
      sks_pkg::S_BUSY: begin
        if (out_free) state_nxt = sks_pkg::S_IDLE;
      end
      default: state_nxt = sks_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    case (state_r)
      sks_pkg::S_IDLE: begin
        ctl.ready  = 1'b1;
        ctl.cmp_en = in_valid;
      end
      sks_pkg::S_BUSY: begin
        ctl.commit = out_free;
      end
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sks_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/core/sorted_key_set.sv
// Top level of the sorted key set: cell row, sequencer, counter and result register.
//
// Keeps up to 256 distinct keys in ascending order in a row of cells. On
// acceptance every cell compares its key with the incoming key at once; once
// the result side is free, the lower bound is decoded from the compare flags,
// an add shifts the tail up one cell in parallel and drops the key into place,
// and the result is loaded into the output register. A new transaction is not
// taken until the previous one has committed; a pending result in the output
// register does not hold up acceptance, only the commit of the following
// transaction. The set is empty after reset.
module sorted_key_set (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // func[1:0], key[65:2], index[73:66], zero fill
  input  logic [sks_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status[2:0], entry_key[66:3], bound_position[75:67], stored_count[84:76], zero fill
  output logic [sks_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int CAP = sks_pkg::CAPACITY;
  localparam int CW  = sks_pkg::CNT_W;

  sks_pkg::ctl_t  ctl;
  logic           out_free;
  logic           in_fire;

  sks_pkg::func_t                   func_r;
  sks_pkg::key_t                    key_r;
  logic [sks_pkg::INDEX_W-1:0]      index_r;
  sks_pkg::cnt_t                    count_r;
  sks_pkg::cnt_t                    count_nxt;

  logic                             out_valid_r;
  logic [sks_pkg::OUT_TDATA_W-1:0]  out_data_r;
  logic [sks_pkg::OUT_TDATA_W-1:0]  out_data_nxt;

  sks_pkg::key_t        cell_key   [CAP];
  sks_pkg::cell_flags_t cell_flags [CAP];
  logic [CAP-1:0]       valid_vec;
  logic [CAP-1:0]       lt_vec;
  logic [CAP-1:0]       eq_vec;
  logic [CAP-1:0]       idx_hit;

  sks_pkg::key_t   in_key;
  sks_pkg::cnt_t   bound;
  sks_pkg::cnt_t   index_ext;
  sks_pkg::key_t   read_key;
  logic            found;
  logic            full;
  logic            do_insert;
  sks_pkg::status_t status;

  assign out_free = !out_valid_r || out_tready;
  assign in_fire  = in_tvalid && in_tready;
  assign in_key   = in_tdata[sks_pkg::IN_KEY_LSB +: sks_pkg::KEY_BITS];

  sks_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .ctl      (ctl)
  );

  assign in_tready = ctl.ready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r  <= sks_pkg::func_t'(in_tdata[sks_pkg::IN_FUNC_LSB +: sks_pkg::FUNC_W]);
      key_r   <= in_key;
      index_r <= in_tdata[sks_pkg::IN_INDEX_LSB +: sks_pkg::INDEX_W];
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAP; gi++) begin : g_cell
      sks_pkg::key_t        prev_key;
      sks_pkg::cell_flags_t prev_flags;
      if (gi == 0) begin : g_head
        assign prev_key   = '0;
        assign prev_flags = '{valid: 1'b1, lt: 1'b1, ge: 1'b0, eq: 1'b0};
      end else begin : g_body
        assign prev_key   = cell_key[gi-1];
        assign prev_flags = cell_flags[gi-1];
      end

      sks_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmp_en     (ctl.cmp_en),
        .cmp_key    (in_key),
        .ins_en     (do_insert),
        .new_key    (key_r),
        .prev_key   (prev_key),
        .prev_flags (prev_flags),
        .key_o      (cell_key[gi]),
        .flags_o    (cell_flags[gi])
      );

      assign valid_vec[gi] = cell_flags[gi].valid;
      assign lt_vec[gi]    = cell_flags[gi].lt;
      assign eq_vec[gi]    = cell_flags[gi].eq;
      assign idx_hit[gi]   = (index_ext == CW'(gi));
    end
  endgenerate

  assign index_ext = CW'(index_r);

  // lt flags form a thermometer over the row; the top set bit marks the bound
  always_comb begin
    bound = '0;
    for (int i = 0; i < CAP; i++) begin
      if (lt_vec[i] && ((i == CAP - 1) || !lt_vec[(i + 1) % CAP])) begin
        bound = bound | CW'(i + 1);
      end
    end
  end

  always_comb begin
    read_key = '0;
    for (int i = 0; i < CAP; i++) begin
      read_key = read_key | (cell_key[i] & {sks_pkg::KEY_BITS{idx_hit[i]}});
    end
  end

  assign found = |eq_vec;
  assign full  = (count_r == CW'(CAP));

  always_comb begin
    do_insert = 1'b0;
    case (func_r)
      sks_pkg::FUNC_ADD: begin
        if (found)     status = sks_pkg::ST_DUPLICATE;
        else if (full) status = sks_pkg::ST_FULL;
        else begin
          status    = sks_pkg::ST_INSERTED;
          do_insert = ctl.commit;
        end
      end
      sks_pkg::FUNC_READ: begin
        status = (index_ext < count_r) ? sks_pkg::ST_ENTRY : sks_pkg::ST_RANGE;
      end
      default: status = found ? sks_pkg::ST_HIT : sks_pkg::ST_MISS;
    endcase
  end

  assign count_nxt = do_insert ? count_r + CW'(1) : count_r;

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[sks_pkg::OUT_STATUS_LSB +: sks_pkg::STATUS_W] = status;
    if (status == sks_pkg::ST_ENTRY) begin
      out_data_nxt[sks_pkg::OUT_ENTRY_LSB +: sks_pkg::KEYF_W] = sks_pkg::KEYF_W'(read_key);
    end
    out_data_nxt[sks_pkg::OUT_BOUND_LSB +: sks_pkg::POSF_W] = sks_pkg::POSF_W'(bound);
    out_data_nxt[sks_pkg::OUT_COUNT_LSB +: sks_pkg::POSF_W] = sks_pkg::POSF_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (ctl.commit)      out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAP))
    else $error("stored count above capacity");

  a_valid_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(count_r))
    else $error("cell valid bits disagree with stored count");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    do_insert |=> count_r == $past(count_r) + CW'(1))
    else $error("insertion did not grow the count");

  a_result_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.commit))
    else $error("result raised without a commit");

endmodule

// File: tb/tb_sorted_key_set.sv
// Self-checking testbench for the sorted key set: stream driver, result checker and predictor.
`timescale 1ns / 1ps

module tb_sorted_key_set;
  import sks_pkg::*;

  localparam int  RANDOM_ITEMS = 1930;
  localparam int  DRAIN_LIMIT  = 100000;
  localparam int  IDX_W        = INDEX_W;
  localparam int  POS_W        = POSF_W;

  typedef struct {
    status_t          status;
    key_t             entry;
    logic [POS_W-1:0] bound;
    logic [POS_W-1:0] count;
  } set_result_t;

  // Mirrors the key set and holds the results still owed by the block
  class key_set_scoreboard;
    key_t         stored [CAPACITY];
    int unsigned  count;
    set_result_t  awaited [$];
    int unsigned  errors;
    int unsigned  seen [8];
    int unsigned  checked;

    function new();
      count   = 0;
      errors  = 0;
      checked = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function void note_request(func_t op, key_t k, logic [IDX_W-1:0] idx);
      int unsigned lb = 0;
      bit          hit;
      set_result_t r;
      for (int i = 0; i < count; i++)
        if (stored[i] < k) lb++;
      hit     = (lb < count) && (stored[lb] == k);
      r.entry = '0;
      r.bound = lb[POS_W-1:0];
      case (op)
        FUNC_ADD: begin
          if (hit) begin
            r.status = ST_DUPLICATE;
          end else if (count >= CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            for (int j = count; j > int'(lb); j--)
              stored[j] = stored[j-1];
            stored[lb] = k;
            count++;
            r.status = ST_INSERTED;
          end
        end
        FUNC_READ: begin
          if (idx < count) begin
            r.entry  = stored[idx];
            r.status = ST_ENTRY;
          end else begin
            r.status = ST_RANGE;
          end
        end
        // spare code behaves as a query
        default: r.status = hit ? ST_HIT : ST_MISS;
      endcase
      r.count = count[POS_W-1:0];
      awaited.push_back(r);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d);
      set_result_t      r;
      logic [STATUS_W-1:0] st;
      key_t             ent;
      logic [POS_W-1:0] bnd;
      logic [POS_W-1:0] cnt;
      st  = d[OUT_STATUS_LSB +: STATUS_W];
      ent = d[OUT_ENTRY_LSB +: KEYF_W];
      bnd = d[OUT_BOUND_LSB +: POSF_W];
      cnt = d[OUT_COUNT_LSB +: POSF_W];
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d key %h",
                 $time, st, ent);
        errors++;
        return;
      end
      r = awaited.pop_front();
      checked++;
      seen[r.status]++;
      if (st !== r.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d", $time, r.status, st);
        errors++;
      end
      if (ent !== r.entry) begin
        $display("%0t: entry_key mismatch, expected %h, actual %h", $time, r.entry, ent);
        errors++;
      end
      if (bnd !== r.bound) begin
        $display("%0t: bound_position mismatch, expected %0d, actual %0d",
                 $time, r.bound, bnd);
        errors++;
      end
      if (cnt !== r.count) begin
        $display("%0t: stored_count mismatch, expected %0d, actual %0d",
                 $time, r.count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  key_set_scoreboard sb;
  int                burst_left = 0;
  int                stall_left = 0;
  int                stall_mode = 0;

  always #4 clk = ~clk;

  sorted_key_set i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Receiver: segments of always-ready, coin-flip and mostly-stalled behaviour
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_left = $urandom_range(20, 200);
        stall_mode = $urandom_range(0, 2);
      end
      stall_left--;
      case (stall_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= ($urandom_range(0, 1) == 1);
        default: out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Sender bursts: random length, random gap, some gapless
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic send_item(func_t op, key_t k, logic [IDX_W-1:0] idx);
    logic [IN_TDATA_W-1:0] d;
    pace_sender();
    d = '0;
    d[IN_FUNC_LSB +: FUNC_W]   = op;
    d[IN_KEY_LSB +: KEYF_W]    = k;
    d[IN_INDEX_LSB +: INDEX_W] = idx;
    in_tdata  <= d;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, k, idx);
  endtask

  initial begin
    key_t              all_ones;
    key_t              k;
    logic [IDX_W-1:0]  idx;
    func_t             op;
    int                pick;
    int                waited;

    sb = new();
    all_ones = '1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty set, extremes, duplicates, hits and misses, reads in and out of range
    send_item(FUNC_QUERY, '0, 8'h00);
    send_item(FUNC_READ,  '0, 8'h00);
    send_item(FUNC_READ,  all_ones, 8'hff);
    send_item(FUNC_SPARE, all_ones, 8'h55);
    send_item(FUNC_ADD,   all_ones, 8'haa);
    send_item(FUNC_ADD,   '0, 8'h00);
    send_item(FUNC_ADD,   64'h8000_0000_0000_0000, 8'h00);
    send_item(FUNC_ADD,   '0, 8'h00);
    send_item(FUNC_ADD,   all_ones, 8'h00);
    send_item(FUNC_QUERY, '0, 8'h00);
    send_item(FUNC_QUERY, all_ones, 8'h00);
    send_item(FUNC_QUERY, 64'd1, 8'h00);
    send_item(FUNC_QUERY, all_ones - 64'd1, 8'h00);
    send_item(FUNC_READ,  '0, 8'h00);
    send_item(FUNC_READ,  '0, 8'h02);
    send_item(FUNC_READ,  '0, 8'h03);
    send_item(FUNC_READ,  all_ones, 8'hff);
    send_item(FUNC_SPARE, '0, 8'haa);
    send_item(FUNC_SPARE, 64'd7, 8'h00);
    send_item(FUNC_ADD,   64'h5555_5555_5555_5555, 8'h55);
    send_item(FUNC_ADD,   64'haaaa_aaaa_aaaa_aaaa, 8'haa);

    // Random: add-heavy until the set fills, then mostly lookups and rejected adds
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (sb.count < CAPACITY)
        op = (pick < 50) ? FUNC_ADD : (pick < 75) ? FUNC_QUERY :
             (pick < 95) ? FUNC_READ : FUNC_SPARE;
      else
        op = (pick < 30) ? FUNC_ADD : (pick < 60) ? FUNC_QUERY :
             (pick < 95) ? FUNC_READ : FUNC_SPARE;

      pick = $urandom_range(0, 9);
      if (sb.count > 0 && pick < 4)
        k = sb.stored[$urandom_range(0, sb.count - 1)];
      else if (sb.count > 0 && pick < 6)
        k = sb.stored[$urandom_range(0, sb.count - 1)] +
            (($urandom_range(0, 1) == 1) ? 64'd1 : all_ones);
      else if (pick == 6)
        k = 64'($urandom_range(0, 15));
      else if (pick == 7)
        k = ($urandom_range(0, 1) == 1) ? all_ones : '0;
      else
        k = {$urandom, $urandom};

      if (op == FUNC_READ && sb.count > 0 && $urandom_range(0, 1) == 1)
        idx = IDX_W'($urandom_range(0, sb.count - 1));
      else
        idx = IDX_W'($urandom_range(0, 255));

      send_item(op, k, idx);
    end

    in_tvalid <= 1'b0;
    waited = 0;
    while (sb.awaited.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);

    $display("Checked %0d results, final set size %0d of %0d.",
             sb.checked, sb.count, CAPACITY);
    $display("Status mix: inserted %0d, duplicate %0d, full %0d, hit %0d, miss %0d, read %0d, range %0d.",
             sb.seen[ST_INSERTED], sb.seen[ST_DUPLICATE], sb.seen[ST_FULL],
             sb.seen[ST_HIT], sb.seen[ST_MISS], sb.seen[ST_ENTRY], sb.seen[ST_RANGE]);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule
